>>> hdl/x86e_pkg.sv
package x86e_pkg;

    typedef struct packed {
        logic [4:0]  mode;
        logic [3:0]  sub_code;
        logic [1:0]  dest_kind;
        logic [4:0]  dest_reg;
        logic [1:0]  src_kind;
        logic [4:0]  src_reg;
        logic [15:0] imm_value;
        logic [3:0]  mem_addressing;
        logic [15:0] disp;
        logic [1:0]  explicit_size;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last;
        logic [2:0] error;
    } t_out_item;

    localparam logic [4:0] M_MOV = 5'd0, M_XCHG = 5'd1, M_INC = 5'd2, M_DEC = 5'd3,
        M_ALU = 5'd4, M_ROL = 5'd5, M_DIV = 5'd6, M_CALL = 5'd7, M_JMP = 5'd8,
        M_JCC = 5'd9, M_INT = 5'd10, M_PUSH = 5'd11, M_POP = 5'd12, M_ONE = 5'd13,
        M_DB = 5'd14, M_DW = 5'd15, M_ORG = 5'd16;

    localparam logic [2:0] E_OK = 3'd0, E_SIZE = 3'd1, E_OPND = 3'd2, E_RANGE = 3'd3,
        E_ORG = 3'd4, E_UNK = 3'd5, E_REG = 3'd6;

    localparam logic [1:0] K_REG = 2'd0, K_MEM = 2'd1, K_IMM = 2'd2, K_BAD = 2'd3;

    // Relative branch kind for the back end
    typedef enum logic [1:0] {
        R_NONE,
        R_AT2,
        R_AT3
    } t_rel;

    // Classified item: fixed bytes plus the branch/org actions left to the back end
    typedef struct packed {
        logic [5:0][7:0] bytes;
        logic [2:0]      count;
        logic [2:0]      error;
        t_rel            rel;
        logic            org;
        logic [15:0]     target;
    } t_cls;

    localparam int QDEPTH = 2;

endpackage

>>> hdl/x86_16bit_instruction_encoder.sv
// Channel | Direction | Handshake              | Beat
// in      | input     | i_valid / o_stall      | t_in_item, one instruction
// out     | output    | o_valid / i_stall      | t_out_item, one byte or status
// Each item emits one beat per byte (1 to 6 bytes), or one status beat for error or org.
// Front classification is combinational; the item enters the queue at its accepting
// edge and the back end registers its beats from the queue head, a byte per cycle unless stalled.
// A two-entry queue decouples them, so input is taken while output is stalled until it fills.
// Synchronous active-low reset clears the location counter and the queue.
module x86_16bit_instruction_encoder
    import x86e_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    t_cls cls, q_data;
    logic full, empty, pop, push;

    x86e_front u_front (.i_item(i_item), .o_cls(cls));

    assign o_stall = full;
    assign push    = i_valid && !full;

    x86e_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(cls),
        .o_full(full), .i_pop(pop), .o_empty(empty), .o_data(q_data)
    );

    x86e_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_cls(q_data),
        .o_pop(pop), .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

endmodule

>>> hdl/x86e_front.sv
module x86e_front
    import x86e_pkg::*;
(
    input  t_in_item i_item,
    output t_cls     o_cls
);

    function automatic logic [2:0] f_chk(input logic [1:0] k, input logic [4:0] r,
                                          input logic [3:0] a);
        if (k == K_REG && r > 5'd19) return E_REG;
        if (k == K_BAD) return E_OPND;
        if (k == K_MEM && a > 4'd8) return E_OPND;
        return E_OK;
    endfunction

    logic [5:0][7:0] b;
    logic [2:0]      n;
    logic [2:0]      err;
    logic [1:0]      es;
    logic [1:0]      nops;
    logic            w;
    logic [2:0]      rmv;
    logic [1:0]      md;
    logic [7:0]      dd;
    logic [4:0]      mr;
    logic [15:0]     imm;
    logic [15:0]     d;
    logic [3:0]      ma;
    logic            use_mem;
    logic [7:0]      op;

    always_comb begin
        b       = '0;
        n       = 3'd0;
        err     = E_OK;
        w       = 1'b0;
        use_mem = 1'b0;
        mr      = 5'd0;
        op      = 8'h00;
        imm     = i_item.imm_value;
        d       = i_item.disp;
        ma      = i_item.mem_addressing;
        o_cls.rel = R_NONE;
        o_cls.org = 1'b0;
        es = (i_item.explicit_size == 2'd3) ? 2'd0 : i_item.explicit_size;
        case (i_item.mode)
            M_MOV, M_XCHG, M_ALU, M_ROL: nops = 2'd2;
            M_INC, M_DEC, M_DIV, M_CALL, M_JMP, M_JCC, M_PUSH, M_POP: nops = 2'd1;
            default: nops = 2'd0;
        endcase
        if (nops != 2'd0)
            err = f_chk(i_item.dest_kind, i_item.dest_reg, ma);
        if (err == E_OK && nops == 2'd2)
            err = f_chk(i_item.src_kind, i_item.src_reg, ma);

        // ModRM fields
        case (ma)
            4'd0: rmv = 3'd6;
            default: rmv = 3'(ma - 4'd1);
        endcase
        if (ma == 4'd0) md = 2'd0;
        else if (d == 16'd0) md = (ma == 4'd7) ? 2'd1 : 2'd0;
        else if (d <= 16'h007F || d >= 16'hFF80) md = 2'd1;
        else md = 2'd2;
        dd = 8'h00;

        if (err == E_OK) begin
            case (i_item.mode)
                M_MOV, M_XCHG, M_ALU: begin
                    if (i_item.mode == M_ALU && i_item.sub_code > 4'd7) begin
                        err = E_OPND;
                    end else if (i_item.dest_kind == K_REG && i_item.src_kind == K_REG) begin
                        if (i_item.dest_reg[4] || i_item.src_reg[4]) err = E_OPND;
                        else if (i_item.dest_reg[3] != i_item.src_reg[3]) err = E_SIZE;
                        else begin
                            op = (i_item.mode == M_MOV) ? 8'h88 :
                                 (i_item.mode == M_XCHG) ? 8'h86 :
                                 {1'b0, i_item.sub_code[2:0], 3'b000};
                            b[0] = op | {7'd0, i_item.dest_reg[3]};
                            b[1] = {2'b11, i_item.src_reg[2:0], i_item.dest_reg[2:0]};
                            n = 3'd2;
                        end
                    end else if (i_item.mode == M_XCHG) begin
                        err = E_OPND;
                    end else if (i_item.mode == M_ALU) begin
                        if (i_item.dest_kind != K_REG || i_item.src_kind != K_IMM
                            || i_item.dest_reg[4]) begin
                            err = E_OPND;
                        end else begin
                            w = i_item.dest_reg[3];
                            if (i_item.dest_reg == 5'd0) begin
                                b[0] = {2'b00, i_item.sub_code[2:0], 3'd4};
                                n = 3'd1;
                            end else if (i_item.dest_reg == 5'd8) begin
                                b[0] = {2'b00, i_item.sub_code[2:0], 3'd5};
                                n = 3'd1;
                            end else begin
                                b[0] = {7'h40, w};
                                b[1] = {2'b11, i_item.sub_code[2:0], i_item.dest_reg[2:0]};
                                n = 3'd2;
                            end
                            if (w) begin
                                b[n] = imm[7:0];
                                b[3'(n + 3'd1)] = imm[15:8];
                                n = 3'(n + 3'd2);
                            end else if (imm > 16'd255) err = E_RANGE;
                            else begin
                                b[n] = imm[7:0];
                                n = 3'(n + 3'd1);
                            end
                        end
                    end else if (i_item.dest_kind == K_MEM && i_item.src_kind == K_REG) begin
                        if (i_item.src_reg[4]) err = E_OPND;
                        else if (es != 2'd0 && es[1] != i_item.src_reg[3]) err = E_SIZE;
                        else begin
                            b[0] = {7'h44, i_item.src_reg[3]};
                            use_mem = 1'b1;
                            mr = i_item.src_reg;
                        end
                    end else if (i_item.dest_kind == K_REG && i_item.src_kind == K_MEM) begin
                        if (i_item.dest_reg[4]) err = E_OPND;
                        else if (es != 2'd0 && es[1] != i_item.dest_reg[3]) err = E_SIZE;
                        else begin
                            b[0] = {7'h45, i_item.dest_reg[3]};
                            use_mem = 1'b1;
                            mr = i_item.dest_reg;
                        end
                    end else if (i_item.dest_kind == K_MEM && i_item.src_kind == K_IMM) begin
                        if (es == 2'd0) err = E_UNK;
                        else if (!es[1] && imm > 16'd255) err = E_RANGE;
                        else begin
                            b[0] = {7'h63, es[1]};
                            use_mem = 1'b1;
                        end
                    end else if (i_item.dest_kind == K_REG && i_item.src_kind == K_IMM) begin
                        if (i_item.dest_reg[4]) err = E_OPND;
                        else if (!i_item.dest_reg[3] && imm > 16'd255) err = E_RANGE;
                        else begin
                            b[0] = 8'hB0 + {4'd0, i_item.dest_reg[3:0]};
                            b[1] = imm[7:0];
                            b[2] = imm[15:8];
                            n = i_item.dest_reg[3] ? 3'd3 : 3'd2;
                        end
                    end else begin
                        err = E_OPND;
                    end
                end
                M_INC, M_DEC: begin
                    if (i_item.dest_kind != K_REG || i_item.dest_reg[4]) err = E_OPND;
                    else if (!i_item.dest_reg[3]) begin
                        b[0] = 8'hFE;
                        b[1] = {4'hC, i_item.mode == M_DEC, i_item.dest_reg[2:0]};
                        n = 3'd2;
                    end else begin
                        b[0] = {4'h4, i_item.mode == M_DEC, i_item.dest_reg[2:0]};
                        n = 3'd1;
                    end
                end
                M_ROL: begin
                    if (i_item.dest_kind != K_REG || i_item.src_kind != K_IMM
                        || i_item.dest_reg[4]) err = E_OPND;
                    else if (imm > 16'd255) err = E_RANGE;
                    else begin
                        b[0] = {7'h60, i_item.dest_reg[3]};
                        b[1] = {5'b11000, i_item.dest_reg[2:0]};
                        b[2] = imm[7:0];
                        n = 3'd3;
                    end
                end
                M_DIV: begin
                    if (i_item.dest_kind != K_REG || i_item.dest_reg[4]) err = E_OPND;
                    else begin
                        b[0] = {7'h7B, i_item.dest_reg[3]};
                        b[1] = {5'b11110, i_item.dest_reg[2:0]};
                        n = 3'd2;
                    end
                end
                M_CALL, M_JMP: begin
                    if (i_item.dest_kind != K_IMM) err = E_OPND;
                    else begin
                        b[0] = (i_item.mode == M_CALL) ? 8'hE8 : 8'hE9;
                        n = 3'd3;
                        o_cls.rel = R_AT2;
                    end
                end
                M_JCC: begin
                    if (i_item.dest_kind != K_IMM) err = E_OPND;
                    else begin
                        b[0] = 8'h0F;
                        b[1] = {4'h8, i_item.sub_code};
                        n = 3'd4;
                        o_cls.rel = R_AT3;
                    end
                end
                M_INT: begin
                    if (imm > 16'd255) err = E_RANGE;
                    else begin
                        b[0] = 8'hCD;
                        b[1] = imm[7:0];
                        n = 3'd2;
                    end
                end
                M_PUSH: begin
                    if (i_item.dest_kind == K_REG) begin
                        if (!i_item.dest_reg[3] && !i_item.dest_reg[4]) err = E_SIZE;
                        else if (i_item.dest_reg[4]) err = E_OPND;
                        else begin
                            b[0] = {5'b01010, i_item.dest_reg[2:0]};
                            n = 3'd1;
                        end
                    end else if (i_item.dest_kind == K_IMM) begin
                        b[1] = imm[7:0];
                        b[2] = imm[15:8];
                        if (imm <= 16'h007F || imm >= 16'hFF80) begin
                            b[0] = 8'h6A;
                            n = 3'd2;
                        end else begin
                            b[0] = 8'h68;
                            n = 3'd3;
                        end
                    end else err = E_OPND;
                end
                M_POP: begin
                    if (i_item.dest_kind != K_REG || i_item.dest_reg[4]
                        || !i_item.dest_reg[3]) err = E_OPND;
                    else begin
                        b[0] = {5'b01011, i_item.dest_reg[2:0]};
                        n = 3'd1;
                    end
                end
                M_ONE: begin
                    n = 3'd1;
                    case (i_item.sub_code)
                        4'd0: b[0] = 8'h60;
                        4'd1: b[0] = 8'h61;
                        4'd2: b[0] = 8'hC3;
                        4'd3: b[0] = 8'hAC;
                        4'd4: b[0] = 8'hAA;
                        default: begin
                            err = E_OPND;
                            n = 3'd0;
                        end
                    endcase
                end
                M_DB: begin
                    if (imm > 16'd255) err = E_RANGE;
                    else begin
                        b[0] = imm[7:0];
                        n = 3'd1;
                    end
                end
                M_DW: begin
                    b[0] = imm[7:0];
                    b[1] = imm[15:8];
                    n = 3'd2;
                end
                M_ORG: o_cls.org = 1'b1;
                default: err = E_OPND;
            endcase
        end

        // Memory forms: opcode, ModRM, displacement, then any immediate
        if (use_mem && err == E_OK) begin
            b[1] = {md, mr[2:0], rmv};
            n = 3'd2;
            if (ma == 4'd0 || md == 2'd2) begin
                b[2] = d[7:0];
                b[3] = d[15:8];
                n = 3'd4;
            end else if (md == 2'd1) begin
                b[2] = d[7:0];
                n = 3'd3;
            end
            if (i_item.dest_kind == K_MEM && i_item.src_kind == K_IMM) begin
                b[n] = imm[7:0];
                if (es[1]) begin
                    b[3'(n + 3'd1)] = imm[15:8];
                    n = 3'(n + 3'd2);
                end else n = 3'(n + 3'd1);
            end
        end
        dd = b[0];

        if (err != E_OK) begin
            n = 3'd0;
            o_cls.rel = R_NONE;
            o_cls.org = 1'b0;
        end
        o_cls.bytes  = {b[5:1], dd};
        o_cls.count  = n;
        o_cls.error  = err;
        o_cls.target = imm;
    end

endmodule

>>> hdl/x86e_queue.sv
module x86e_queue
    import x86e_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cls o_data
);

    localparam int AW = $clog2(QDEPTH);

    t_cls            r_mem [QDEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= AW'(r_wp + 1'b1);
            if (i_pop)  r_rp <= AW'(r_rp + 1'b1);
            r_cnt <= (AW+1)'(r_cnt + {AW'(0), i_push} - {AW'(0), i_pop});
        end
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue overflow");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue underflow");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(QDEPTH))
        else $error("queue count out of range");

endmodule

>>> hdl/x86e_back.sv
module x86e_back
    import x86e_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_cls      i_cls,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic [15:0] r_lc, n_lc;
    logic [2:0]  r_idx, n_idx;
    logic        r_valid, n_valid;
    t_out_item   r_item, n_item;
    logic [15:0] rel;
    logic        take;
    logic [7:0]  byte_v;
    logic        fin;
    logic        org_err;

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign take    = !r_valid || !i_stall;

    always_comb begin
        // Counter is advanced per byte, so r_lc minus r_idx is the item start
        rel = i_cls.target - (r_lc - {13'd0, r_idx}
              + ((i_cls.rel == R_AT3) ? 16'd4 : 16'd3));
        byte_v = i_cls.bytes[r_idx];
        if (i_cls.rel != R_NONE) begin
            if (r_idx == 3'(i_cls.count - 3'd2)) byte_v = rel[7:0];
            if (r_idx == 3'(i_cls.count - 3'd1)) byte_v = rel[15:8];
        end
        org_err = i_cls.org && (i_cls.target < r_lc);
        n_lc    = r_lc;
        n_idx   = r_idx;
        n_valid = r_valid && i_stall;
        n_item  = r_item;
        o_pop   = 1'b0;
        fin     = 1'b0;
        if (take && !i_empty) begin
            n_valid = 1'b1;
            if (i_cls.count == 3'd0) begin
                fin = 1'b1;
                n_item = '{out_byte: 8'h00, has_byte: 1'b0, last: 1'b1,
                           error: org_err ? E_ORG : i_cls.error};
                if (i_cls.org && !org_err) n_lc = i_cls.target;
            end else begin
                fin = (r_idx == 3'(i_cls.count - 3'd1));
                n_item = '{out_byte: byte_v, has_byte: 1'b1, last: fin, error: E_OK};
                n_lc = r_lc + 16'd1;
            end
            o_pop = fin;
            n_idx = fin ? 3'd0 : 3'(r_idx + 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc    <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_lc    <= n_lc;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_idx == 3'd0)
        else $error("byte index not cleared after item");
    a_err_nobyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_item.error != E_OK) |-> (!r_item.has_byte && r_item.last))
        else $error("error beat carries a byte");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> (r_valid && $stable(r_lc)))
        else $error("state moved under stall");

endmodule

>>> bench/tb_x86_16bit_instruction_encoder.sv
module tb_x86_16bit_instruction_encoder;
    import x86e_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    x86_16bit_instruction_encoder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    localparam int WATCHDOG = 4000;

    t_in_item  pending_instrs[$];
    t_out_item expected_bytes[$];
    logic [15:0] loc_ctr;
    int errors;
    int idle_cnt;
    int tx_wait;
    int rx_wait;
    int hold_cycles;
    bit sync_req;
    bit stim_done;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [2:0] opnd_error(logic [1:0] kind, logic [4:0] r,
                                              logic [3:0] ma);
        if (kind == K_REG && r > 19) return E_REG;
        if (kind == K_BAD) return E_OPND;
        if (kind == K_MEM && ma > 8) return E_OPND;
        return E_OK;
    endfunction

    // Append ModRM and displacement for a memory operand
    function automatic void add_modrm(ref logic [7:0] b[$], input logic [2:0] regf,
                                      input logic [3:0] ma, input logic [15:0] d);
        logic [2:0] rm;
        logic [1:0] md;
        rm = (ma == 0) ? 3'd6 : 3'(ma - 1);
        if (ma == 0) md = 2'd0;
        else if (d == 0) md = (ma == 7) ? 2'd1 : 2'd0;
        else if (d <= 16'h7F || d >= 16'hFF80) md = 2'd1;
        else md = 2'd2;
        b.push_back({md, regf, rm});
        if (ma == 0 || md == 2) begin
            b.push_back(d[7:0]);
            b.push_back(d[15:8]);
        end else if (md == 1) begin
            b.push_back(d[7:0]);
        end
    endfunction

    // Encode one instruction, update the location counter, queue expected beats
    task automatic encode_instr(t_in_item it);
        logic [7:0] b[$];
        logic [2:0] err;
        logic [1:0] es;
        logic       w;
        logic [7:0] op;
        logic [15:0] rel;
        int nops;
        int k;
        logic [4:0] dr, sr;
        logic [15:0] imm;
        err = E_OK;
        es = (it.explicit_size == 3) ? 2'd0 : it.explicit_size;
        dr = it.dest_reg;
        sr = it.src_reg;
        imm = it.imm_value;
        nops = 0;
        if (it.mode inside {M_MOV, M_XCHG, M_ALU, M_ROL}) nops = 2;
        else if ((it.mode >= M_INC && it.mode <= M_JCC) || it.mode == M_PUSH
                 || it.mode == M_POP) nops = 1;
        if (nops >= 1) err = opnd_error(it.dest_kind, dr, it.mem_addressing);
        if (err == E_OK && nops == 2) err = opnd_error(it.src_kind, sr, it.mem_addressing);
        if (err == E_OK) begin
            case (it.mode)
                M_MOV, M_XCHG, M_ALU: begin
                    if (it.mode == M_ALU && it.sub_code > 7) err = E_OPND;
                    else if (it.dest_kind == K_REG && it.src_kind == K_REG) begin
                        op = (it.mode == M_MOV) ? 8'h88 : (it.mode == M_XCHG) ? 8'h86 :
                            {1'b0, it.sub_code[2:0], 3'b0};
                        if (dr >= 16 || sr >= 16) err = E_OPND;
                        else if (dr[3] != sr[3]) err = E_SIZE;
                        else begin
                            b.push_back(op | {7'd0, dr[3]});
                            b.push_back({2'b11, sr[2:0], dr[2:0]});
                        end
                    end else if (it.mode == M_XCHG) begin
                        err = E_OPND;
                    end else if (it.mode == M_ALU) begin
                        if (it.dest_kind != K_REG || it.src_kind != K_IMM || dr >= 16)
                            err = E_OPND;
                        else begin
                            w = dr[3];
                            if (dr == 0) b.push_back({2'b0, it.sub_code[2:0], 3'd4});
                            else if (dr == 8) b.push_back({2'b0, it.sub_code[2:0], 3'd5});
                            else begin
                                b.push_back({7'b1000000, w});
                                b.push_back({2'b11, it.sub_code[2:0], dr[2:0]});
                            end
                            if (w) begin
                                b.push_back(imm[7:0]);
                                b.push_back(imm[15:8]);
                            end else if (imm > 255) err = E_RANGE;
                            else b.push_back(imm[7:0]);
                        end
                    end else if (it.dest_kind == K_MEM && it.src_kind == K_REG) begin
                        if (sr >= 16) err = E_OPND;
                        else if (es != 0 && es - 1 != sr[3]) err = E_SIZE;
                        else begin
                            b.push_back({7'b1000100, sr[3]});
                            add_modrm(b, sr[2:0], it.mem_addressing, it.disp);
                        end
                    end else if (it.dest_kind == K_REG && it.src_kind == K_MEM) begin
                        if (dr >= 16) err = E_OPND;
                        else if (es != 0 && es - 1 != dr[3]) err = E_SIZE;
                        else begin
                            b.push_back({7'b1000101, dr[3]});
                            add_modrm(b, dr[2:0], it.mem_addressing, it.disp);
                        end
                    end else if (it.dest_kind == K_MEM && it.src_kind == K_IMM) begin
                        if (es == 0) err = E_UNK;
                        else begin
                            w = (es == 2);
                            b.push_back({7'b1100011, w});
                            add_modrm(b, 3'd0, it.mem_addressing, it.disp);
                            if (w) begin
                                b.push_back(imm[7:0]);
                                b.push_back(imm[15:8]);
                            end else if (imm > 255) err = E_RANGE;
                            else b.push_back(imm[7:0]);
                        end
                    end else if (it.dest_kind == K_REG && it.src_kind == K_IMM) begin
                        if (dr >= 16) err = E_OPND;
                        else begin
                            b.push_back(8'hB0 + dr);
                            b.push_back(imm[7:0]);
                            if (dr >= 8) b.push_back(imm[15:8]);
                            else if (imm > 255) err = E_RANGE;
                        end
                    end else err = E_OPND;
                end
                M_INC, M_DEC: begin
                    if (it.dest_kind != K_REG || dr >= 16) err = E_OPND;
                    else if (dr < 8) begin
                        b.push_back(8'hFE);
                        b.push_back({4'hC, it.mode == M_DEC, dr[2:0]});
                    end else b.push_back({4'h4, it.mode == M_DEC, dr[2:0]});
                end
                M_ROL: begin
                    if (it.dest_kind != K_REG || it.src_kind != K_IMM || dr >= 16)
                        err = E_OPND;
                    else if (imm > 255) err = E_RANGE;
                    else begin
                        b.push_back({7'b1100000, dr[3]});
                        b.push_back({5'b11000, dr[2:0]});
                        b.push_back(imm[7:0]);
                    end
                end
                M_DIV: begin
                    if (it.dest_kind != K_REG || dr >= 16) err = E_OPND;
                    else begin
                        b.push_back({7'b1111011, dr[3]});
                        b.push_back({5'b11110, dr[2:0]});
                    end
                end
                M_CALL, M_JMP, M_JCC: begin
                    if (it.dest_kind != K_IMM) err = E_OPND;
                    else begin
                        if (it.mode == M_JCC) begin
                            b.push_back(8'h0F);
                            b.push_back({4'h8, it.sub_code});
                        end else b.push_back((it.mode == M_CALL) ? 8'hE8 : 8'hE9);
                        rel = imm - (loc_ctr + 16'(b.size()) + 16'd2);
                        b.push_back(rel[7:0]);
                        b.push_back(rel[15:8]);
                    end
                end
                M_INT: begin
                    if (imm > 255) err = E_RANGE;
                    else begin
                        b.push_back(8'hCD);
                        b.push_back(imm[7:0]);
                    end
                end
                M_PUSH: begin
                    if (it.dest_kind == K_REG) begin
                        if (dr < 8) err = E_SIZE;
                        else if (dr >= 16) err = E_OPND;
                        else b.push_back({5'b01010, dr[2:0]});
                    end else if (it.dest_kind == K_IMM) begin
                        if (imm <= 16'h7F || imm >= 16'hFF80) begin
                            b.push_back(8'h6A);
                            b.push_back(imm[7:0]);
                        end else begin
                            b.push_back(8'h68);
                            b.push_back(imm[7:0]);
                            b.push_back(imm[15:8]);
                        end
                    end else err = E_OPND;
                end
                M_POP: begin
                    if (it.dest_kind != K_REG || dr < 8 || dr >= 16) err = E_OPND;
                    else b.push_back({5'b01011, dr[2:0]});
                end
                M_ONE: begin
                    case (it.sub_code)
                        4'd0: b.push_back(8'h60);
                        4'd1: b.push_back(8'h61);
                        4'd2: b.push_back(8'hC3);
                        4'd3: b.push_back(8'hAC);
                        4'd4: b.push_back(8'hAA);
                        default: err = E_OPND;
                    endcase
                end
                M_DB: begin
                    if (imm > 255) err = E_RANGE;
                    else b.push_back(imm[7:0]);
                end
                M_DW: begin
                    b.push_back(imm[7:0]);
                    b.push_back(imm[15:8]);
                end
                M_ORG: begin
                    if (imm < loc_ctr) err = E_ORG;
                    else loc_ctr = imm;
                end
                default: err = E_OPND;
            endcase
        end
        if (err != E_OK || b.size() == 0) begin
            expected_bytes.push_back('{8'h00, 1'b0, 1'b1, err});
        end else begin
            for (k = 0; k < b.size(); k++)
                expected_bytes.push_back('{b[k], 1'b1, k == b.size() - 1, E_OK});
            loc_ctr = loc_ctr + 16'(b.size());
        end
    endtask

    function automatic t_in_item rand_item();
        t_in_item it;
        it = t_in_item'({$urandom, $urandom, $urandom});
        return it;
    endfunction

    // Mostly well-formed instructions with random content
    function automatic t_in_item legal_item();
        t_in_item it;
        it = rand_item();
        it.mode = 5'($urandom_range(0, 15));
        it.sub_code = 4'($urandom_range(0, 15));
        it.dest_kind = 2'($urandom_range(0, 2));
        it.src_kind = 2'($urandom_range(0, 2));
        it.dest_reg = 5'($urandom_range(0, 15));
        it.src_reg = ($urandom_range(0, 1)) ? {1'b0, it.dest_reg[3], 3'($urandom)}
                                            : 5'($urandom_range(0, 19));
        it.mem_addressing = 4'($urandom_range(0, 8));
        if ($urandom_range(0, 1)) it.imm_value = 16'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: it.disp = 16'd0;
            1: it.disp = 16'($urandom_range(0, 127));
            2: it.disp = 16'hFF80 | 16'($urandom_range(0, 127));
            default: it.disp = 16'($urandom);
        endcase
        if (it.mode inside {M_ALU, M_ONE}) it.sub_code = 4'($urandom_range(0, 7));
        if (it.mode inside {M_CALL, M_JMP, M_JCC} && $urandom_range(0, 3) != 0)
            it.dest_kind = K_IMM;
        if (it.mode inside {M_ALU, M_ROL} && $urandom_range(0, 2) != 0) begin
            it.dest_kind = K_REG;
            it.src_kind = K_IMM;
        end
        return it;
    endfunction

    function automatic t_in_item mk(logic [4:0] m, logic [3:0] s, logic [1:0] dk,
                                    logic [4:0] dr, logic [1:0] sk, logic [4:0] sr,
                                    logic [15:0] imm, logic [3:0] ma, logic [15:0] d,
                                    logic [1:0] es);
        return '{m, s, dk, dr, sk, sr, imm, ma, d, es};
    endfunction

    initial begin
        int n;
        t_in_item it;
        // Directed: extremes, most operations, each error path
        pending_instrs.push_back(mk(M_MOV, 0, K_REG, 8, K_REG, 11, 0, 0, 0, 0));
        pending_instrs.push_back(mk(M_MOV, 0, K_REG, 1, K_REG, 9, 0, 0, 0, 0));
        pending_instrs.push_back(mk(M_MOV, 0, K_MEM, 0, K_REG, 15, 0, 0, 16'hFFFF, 0));
        pending_instrs.push_back(mk(M_MOV, 0, K_REG, 3, K_MEM, 0, 0, 7, 0, 1));
        pending_instrs.push_back(mk(M_MOV, 0, K_MEM, 0, K_IMM, 0, 16'hFFFF, 4, 16'h1234, 2));
        pending_instrs.push_back(mk(M_MOV, 0, K_MEM, 0, K_IMM, 0, 16'h100, 1, 16'h80, 1));
        pending_instrs.push_back(mk(M_MOV, 0, K_MEM, 0, K_IMM, 0, 5, 2, 5, 3));
        pending_instrs.push_back(mk(M_MOV, 0, K_REG, 19, K_IMM, 0, 5, 0, 0, 0));
        pending_instrs.push_back(mk(M_XCHG, 0, K_REG, 31, K_REG, 0, 0, 0, 0, 0));
        pending_instrs.push_back(mk(M_ALU, 7, K_REG, 0, K_IMM, 0, 255, 0, 0, 0));
        pending_instrs.push_back(mk(M_ALU, 5, K_REG, 13, K_IMM, 0, 16'hABCD, 0, 0, 0));
        pending_instrs.push_back(mk(M_ALU, 15, K_REG, 1, K_REG, 1, 0, 0, 0, 0));
        pending_instrs.push_back(mk(M_INC, 0, K_REG, 7, K_REG, 0, 0, 0, 0, 0));
        pending_instrs.push_back(mk(M_DEC, 0, K_REG, 12, K_REG, 0, 0, 0, 0, 0));
        pending_instrs.push_back(mk(M_ROL, 0, K_REG, 10, K_IMM, 0, 256, 0, 0, 0));
        pending_instrs.push_back(mk(M_DIV, 0, K_REG, 15, K_BAD, 0, 0, 15, 0, 0));
        pending_instrs.push_back(mk(M_JCC, 15, K_IMM, 0, K_REG, 0, 16'h0000, 0, 0, 0));
        pending_instrs.push_back(mk(M_CALL, 0, K_MEM, 0, K_REG, 0, 0, 9, 0, 0));
        pending_instrs.push_back(mk(M_INT, 0, K_REG, 0, K_REG, 0, 16'hFF, 0, 0, 0));
        pending_instrs.push_back(mk(M_PUSH, 0, K_IMM, 0, K_REG, 0, 16'hFF80, 0, 0, 0));
        pending_instrs.push_back(mk(M_PUSH, 0, K_IMM, 0, K_REG, 0, 16'h0080, 0, 0, 0));
        pending_instrs.push_back(mk(M_PUSH, 0, K_REG, 2, K_REG, 0, 0, 0, 0, 0));
        pending_instrs.push_back(mk(M_POP, 0, K_REG, 16, K_REG, 0, 0, 0, 0, 0));
        pending_instrs.push_back(mk(M_ONE, 5, K_REG, 0, K_REG, 0, 0, 0, 0, 0));
        pending_instrs.push_back(mk(M_DB, 0, K_REG, 0, K_REG, 0, 256, 0, 0, 0));
        pending_instrs.push_back(mk(M_ORG, 0, K_REG, 0, K_REG, 0, 16'h0000, 0, 0, 0));
        pending_instrs.push_back(mk(M_ORG, 0, K_REG, 0, K_REG, 0, 16'hFFF0, 0, 0, 0));
        pending_instrs.push_back(mk(5'd31, 0, K_REG, 0, K_REG, 0, 0, 0, 0, 0));
        for (n = 0; n < 92; n++) begin
            if ($urandom_range(0, 4) == 0) it = rand_item();
            else it = legal_item();
            // Keep org occasional
            if (it.mode == M_ORG && $urandom_range(0, 1)) it.mode = M_DW;
            pending_instrs.push_back(it);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_item <= '0;
            tx_wait <= 0;
            sync_req <= 1'b0;
            stim_done <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                encode_instr(i_item);
                void'(pending_instrs.pop_front());
            end
            if (i_valid && o_stall) begin
                // hold the beat
            end else if (sync_req) begin
                i_valid <= 1'b0;
                if (expected_bytes.size() == 0) sync_req <= 1'b0;
            end else if (pending_instrs.size() == 0 || (i_valid && !o_stall
                         && pending_instrs.size() == 0)) begin
                i_valid <= 1'b0;
                stim_done <= 1'b1;
            end else if (tx_wait > 0) begin
                i_valid <= 1'b0;
                tx_wait <= tx_wait - 1;
            end else begin
                i_valid <= 1'b1;
                i_item <= pending_instrs[0];
                if (pending_instrs.size() == 60) sync_req <= 1'b1;
                tx_wait <= (pending_instrs.size() > 90 || pending_instrs.size() < 30) ? 0
                           : $urandom_range(0, 14);
            end
        end
    end

    // Monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait <= 0;
            hold_cycles <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected beat byte=%h", o_item.out_byte);
                    errors++;
                end else begin
                    if (o_item.out_byte !== expected_bytes[0].out_byte) begin
                        $error("out_byte exp %h got %h", expected_bytes[0].out_byte,
                               o_item.out_byte);
                        errors++;
                    end
                    if (o_item.has_byte !== expected_bytes[0].has_byte) begin
                        $error("has_byte exp %b got %b", expected_bytes[0].has_byte,
                               o_item.has_byte);
                        errors++;
                    end
                    if (o_item.last !== expected_bytes[0].last) begin
                        $error("last exp %b got %b", expected_bytes[0].last, o_item.last);
                        errors++;
                    end
                    if (o_item.error !== expected_bytes[0].error) begin
                        $error("error exp %0d got %0d", expected_bytes[0].error,
                               o_item.error);
                        errors++;
                    end
                    void'(expected_bytes.pop_front());
                end
            end
            // long hold-off once, during the directed stretch
            if (hold_cycles == 0 && pending_instrs.size() == 100) begin
                hold_cycles <= 80;
                i_stall <= 1'b1;
            end else if (hold_cycles > 1) begin
                hold_cycles <= hold_cycles - 1;
            end else if (hold_cycles == 1) begin
                hold_cycles <= -1;
                i_stall <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait <= rx_wait - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if (o_valid && pending_instrs.size() < 80 && pending_instrs.size() > 20)
                    rx_wait <= $urandom_range(0, 14);
            end
        end
    end

    initial begin
        errors = 0;
        idle_cnt = 0;
        loc_ctr = '0;
        @(posedge i_rst_n);
        while (!(stim_done && expected_bytes.size() == 0) && idle_cnt < WATCHDOG) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cnt = 0;
            else idle_cnt++;
        end
        if (idle_cnt >= WATCHDOG) begin
            $display("tb_x86_16bit_instruction_encoder failed");
        end else begin
            repeat (20) @(posedge i_clk);
            if (errors == 0) $display("tb_x86_16bit_instruction_encoder passed");
            else $display("tb_x86_16bit_instruction_encoder failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/x86e_pkg.sv
hdl/x86e_front.sv
hdl/x86e_queue.sv
hdl/x86e_back.sv
hdl/x86_16bit_instruction_encoder.sv
bench/tb_x86_16bit_instruction_encoder.sv
